// ===== hdl/cpm_pkg.sv =====
package cpm_pkg;

  localparam int unsigned MAX_TASKS_DEF     = 1024;
  localparam int unsigned MAX_EDGES_DEF     = 4096;
  localparam int unsigned DURATION_BITS_DEF = 16;

  localparam int unsigned MAKESPAN_W   = 26;
  localparam int unsigned TASK_COUNT_W = 11;
  localparam logic [TASK_COUNT_W-1:0] TASK_COUNT_RST = TASK_COUNT_W'(1);
  localparam logic [MAKESPAN_W-1:0]   MAKESPAN_MAX   = '1;

  typedef enum logic [1:0] {
    CMD_SET_DURATION = 2'd0,
    CMD_ADD_EDGE     = 2'd1,
    CMD_RUN          = 2'd2,
    CMD_NOP          = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        command;
    logic [9:0]  task_index;
    logic [15:0] duration_value;
    logic [9:0]  edge_from;
    logic [9:0]  edge_to;
  } in_word_t;

  typedef struct packed {
    logic [MAKESPAN_W-1:0]   makespan;
    logic [TASK_COUNT_W-1:0] ordered_count;
    logic                    cycle_found;
    logic                    edge_overflow;
  } out_word_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_MAX,
    ALU_INC,
    ALU_DEC
  } alu_op_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_EDGE_RD,
    S_EDGE_WR,
    S_INIT,
    S_DEG_HEAD,
    S_DEG_FIRST,
    S_DEG_CHK,
    S_DEG_TGT,
    S_DEG_INC,
    S_SCAN,
    S_SCAN_CHK,
    S_POP,
    S_POP_U,
    S_POP_F,
    S_POP_S,
    S_REL_CHK,
    S_REL_TGT,
    S_REL_EST,
    S_REL_DEG,
    S_DONE
  } state_e;

endpackage

// ===== hdl/cpm_ram.sv =====
module cpm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cpm_alu.sv =====
module cpm_alu
  import cpm_pkg::*;
#(
  parameter int unsigned W = 26
) (
  input  alu_op_e      op_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] res_o,
  output logic         zero_o
);

  always_comb begin
    unique case (op_i)
      ALU_ADD: res_o = a_i + b_i;
      ALU_MAX: res_o = (a_i > b_i) ? a_i : b_i;
      ALU_INC: res_o = a_i + W'(1);
      ALU_DEC: res_o = a_i - W'(1);
      default: res_o = a_i;
    endcase
  end

  assign zero_o = (res_o == '0);

endmodule

// ===== hdl/critical_path_makespan_core.sv =====
// An add-edge word reads its source's list head before it writes the edge. A run
// does all of its work on one shared add/compare unit and on one read port and
// one write port per store. One word is in work at a time. After reset, and
// after every run, a clearing pass empties the edge list heads; no input word is
// taken meanwhile, though configuration writes are.
module critical_path_makespan_core
  import cpm_pkg::*;
#(
  parameter int unsigned MAX_TASKS     = MAX_TASKS_DEF,
  parameter int unsigned MAX_EDGES     = MAX_EDGES_DEF,
  parameter int unsigned DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  in_word_t                in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output out_word_t               out_word_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [TASK_COUNT_W-1:0] cfg_data_i
);

  // Widths of indices, pointers and counters. An edge pointer can also code
  // MAX_EDGES, one beyond the edge store's entries, which marks an empty list.
  localparam int unsigned TIDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int unsigned EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EP_W   = $clog2(MAX_EDGES + 1);
  localparam int unsigned DEG_W  = EP_W;
  // The longest chain is at most MAX_TASKS full durations.
  localparam int unsigned SPAN_W = DURATION_BITS + TIDX_W;
  localparam int unsigned ALU_W  = (SPAN_W > DEG_W) ? SPAN_W : DEG_W;
  localparam int unsigned OUT_W  = (SPAN_W > MAKESPAN_W) ? SPAN_W : MAKESPAN_W;
  localparam logic [EP_W-1:0] EMPTY = EP_W'(MAX_EDGES);

  // Control and datapath registers.
  state_e                  state_q, state_d;
  logic [TASK_COUNT_W-1:0] task_count_q;
  logic [CNT_W-1:0]        u_q, u_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CNT_W-1:0]        head_q, head_d;
  logic [CNT_W-1:0]        tail_q, tail_d;
  logic [EP_W-1:0]         e_q, e_d;
  logic [EP_W-1:0]         etot_q, etot_d;
  logic                    ovf_q, ovf_d;
  logic [TIDX_W-1:0]       v_q, v_d;
  logic [TIDX_W-1:0]       pu_q, pu_d;
  logic [TIDX_W-1:0]       from_q, from_d;
  logic [TIDX_W-1:0]       to_q, to_d;
  logic [SPAN_W-1:0]       fin_q, fin_d;
  logic [SPAN_W-1:0]       span_q, span_d;
  logic                    out_valid_q, out_valid_d;
  out_word_t               out_word_q, out_word_d;

  // Store ports.
  logic                     dur_we, dur_re;
  logic [TIDX_W-1:0]        dur_waddr, dur_raddr;
  logic [DURATION_BITS-1:0] dur_wdata, dur_rdata;

  logic                     deg_we, deg_re;
  logic [TIDX_W-1:0]        deg_waddr, deg_raddr;
  logic [DEG_W-1:0]         deg_wdata, deg_rdata;

  logic                     first_we, first_re;
  logic [TIDX_W-1:0]        first_waddr, first_raddr;
  logic [EP_W-1:0]          first_wdata, first_rdata;

  logic                     tgt_we, tgt_re;
  logic [EIDX_W-1:0]        tgt_waddr, tgt_raddr;
  logic [TIDX_W-1:0]        tgt_wdata, tgt_rdata;

  logic                     link_we, link_re;
  logic [EIDX_W-1:0]        link_waddr, link_raddr;
  logic [EP_W-1:0]          link_wdata, link_rdata;

  logic                     queue_we, queue_re;
  logic [TIDX_W-1:0]        queue_waddr, queue_raddr;
  logic [TIDX_W-1:0]        queue_wdata, queue_rdata;

  logic                     est_we, est_re;
  logic [TIDX_W-1:0]        est_waddr, est_raddr;
  logic [SPAN_W-1:0]        est_wdata, est_rdata;

  // Shared add/compare unit.
  alu_op_e            alu_op;
  logic [ALU_W-1:0]   alu_a, alu_b, alu_res;
  logic               alu_zero;

  logic               in_fire;
  logic [OUT_W-1:0]   span_wide;

  cpm_ram #(.WIDTH(DURATION_BITS), .DEPTH(MAX_TASKS)) u_dur (
    .clk_i, .we_i(dur_we), .waddr_i(dur_waddr), .wdata_i(dur_wdata),
    .re_i(dur_re), .raddr_i(dur_raddr), .rdata_o(dur_rdata)
  );
  cpm_ram #(.WIDTH(DEG_W), .DEPTH(MAX_TASKS)) u_deg (
    .clk_i, .we_i(deg_we), .waddr_i(deg_waddr), .wdata_i(deg_wdata),
    .re_i(deg_re), .raddr_i(deg_raddr), .rdata_o(deg_rdata)
  );
  cpm_ram #(.WIDTH(EP_W), .DEPTH(MAX_TASKS)) u_first (
    .clk_i, .we_i(first_we), .waddr_i(first_waddr), .wdata_i(first_wdata),
    .re_i(first_re), .raddr_i(first_raddr), .rdata_o(first_rdata)
  );
  cpm_ram #(.WIDTH(TIDX_W), .DEPTH(MAX_EDGES)) u_tgt (
    .clk_i, .we_i(tgt_we), .waddr_i(tgt_waddr), .wdata_i(tgt_wdata),
    .re_i(tgt_re), .raddr_i(tgt_raddr), .rdata_o(tgt_rdata)
  );
  cpm_ram #(.WIDTH(EP_W), .DEPTH(MAX_EDGES)) u_link (
    .clk_i, .we_i(link_we), .waddr_i(link_waddr), .wdata_i(link_wdata),
    .re_i(link_re), .raddr_i(link_raddr), .rdata_o(link_rdata)
  );
  cpm_ram #(.WIDTH(TIDX_W), .DEPTH(MAX_TASKS)) u_queue (
    .clk_i, .we_i(queue_we), .waddr_i(queue_waddr), .wdata_i(queue_wdata),
    .re_i(queue_re), .raddr_i(queue_raddr), .rdata_o(queue_rdata)
  );
  cpm_ram #(.WIDTH(SPAN_W), .DEPTH(MAX_TASKS)) u_est (
    .clk_i, .we_i(est_we), .waddr_i(est_waddr), .wdata_i(est_wdata),
    .re_i(est_re), .raddr_i(est_raddr), .rdata_o(est_rdata)
  );

  cpm_alu #(.W(ALU_W)) u_alu (
    .op_i(alu_op), .a_i(alu_a), .b_i(alu_b), .res_o(alu_res), .zero_o(alu_zero)
  );

  // The configuration port is always open; the task count is to be written only
  // while the block is idle, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign span_wide   = OUT_W'(span_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= TASK_COUNT_RST;
    end else if (cfg_valid_i) begin
      task_count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      u_q         <= '0;
      cnt_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      e_q         <= '0;
      etot_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      u_q         <= u_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      e_q         <= e_d;
      etot_q      <= etot_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    pu_q       <= pu_d;
    from_q     <= from_d;
    to_q       <= to_d;
    fin_q      <= fin_d;
    span_q     <= span_d;
    out_word_q <= out_word_d;
  end

  // Sequencer. Every step issues at most one read per store; the data is taken
  // in a later state, as read data holds until the next read of that store.
  always_comb begin
    state_d     = state_q;
    u_d         = u_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    tail_d      = tail_q;
    e_d         = e_q;
    etot_d      = etot_q;
    ovf_d       = ovf_q;
    v_d         = v_q;
    pu_d        = pu_q;
    from_d      = from_q;
    to_d        = to_q;
    fin_d       = fin_q;
    span_d      = span_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q && !out_ready_i;

    dur_we = 1'b0;   dur_re = 1'b0;   dur_waddr = '0;   dur_raddr = '0;
    dur_wdata = '0;
    deg_we = 1'b0;   deg_re = 1'b0;   deg_waddr = '0;   deg_raddr = '0;
    deg_wdata = '0;
    first_we = 1'b0; first_re = 1'b0; first_waddr = '0; first_raddr = '0;
    first_wdata = '0;
    tgt_we = 1'b0;   tgt_re = 1'b0;   tgt_waddr = '0;   tgt_raddr = '0;
    tgt_wdata = '0;
    link_we = 1'b0;  link_re = 1'b0;  link_waddr = '0;  link_raddr = '0;
    link_wdata = '0;
    queue_we = 1'b0; queue_re = 1'b0; queue_waddr = '0; queue_raddr = '0;
    queue_wdata = '0;
    est_we = 1'b0;   est_re = 1'b0;   est_waddr = '0;   est_raddr = '0;
    est_wdata = '0;

    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;

    unique case (state_q)
      // Empty every edge list head, forget the edge store and clear the overflow flag.
      S_CLEAR: begin
        first_we    = 1'b1;
        first_waddr = u_q[TIDX_W-1:0];
        first_wdata = EMPTY;
        etot_d      = '0;
        ovf_d       = 1'b0;
        if (u_q == CNT_W'(MAX_TASKS - 1)) begin
          u_d     = '0;
          state_d = S_IDLE;
        end else begin
          u_d = u_q + CNT_W'(1);
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          case (in_word_i.command)
            CMD_SET_DURATION: begin
              if (32'(in_word_i.task_index) < MAX_TASKS) begin
                dur_we    = 1'b1;
                dur_waddr = TIDX_W'(in_word_i.task_index);
                dur_wdata = DURATION_BITS'(in_word_i.duration_value);
              end
            end
            CMD_ADD_EDGE: begin
              // Endpoints beyond storage are ignored without a flag.
              if (32'(in_word_i.edge_from) < MAX_TASKS &&
                  32'(in_word_i.edge_to) < MAX_TASKS) begin
                if (etot_q == EMPTY) begin
                  ovf_d = 1'b1;
                end else begin
                  from_d  = TIDX_W'(in_word_i.edge_from);
                  to_d    = TIDX_W'(in_word_i.edge_to);
                  state_d = S_EDGE_RD;
                end
              end
            end
            CMD_RUN: begin
              if (32'(task_count_q) > MAX_TASKS) begin
                cnt_d = CNT_W'(MAX_TASKS);
              end else begin
                cnt_d = CNT_W'(task_count_q);
              end
              u_d     = '0;
              state_d = S_INIT;
            end
            default: begin
            end
          endcase
        end
      end

      S_EDGE_RD: begin
        first_re    = 1'b1;
        first_raddr = from_q;
        state_d     = S_EDGE_WR;
      end

      // Push the new edge at the head of its source's list.
      S_EDGE_WR: begin
        tgt_we      = 1'b1;
        tgt_waddr   = etot_q[EIDX_W-1:0];
        tgt_wdata   = to_q;
        link_we     = 1'b1;
        link_waddr  = etot_q[EIDX_W-1:0];
        link_wdata  = first_rdata;
        first_we    = 1'b1;
        first_waddr = from_q;
        first_wdata = etot_q;
        etot_d      = etot_q + EP_W'(1);
        state_d     = S_IDLE;
      end

      S_INIT: begin
        if (u_q < cnt_q) begin
          deg_we    = 1'b1;
          deg_waddr = u_q[TIDX_W-1:0];
          deg_wdata = '0;
          est_we    = 1'b1;
          est_waddr = u_q[TIDX_W-1:0];
          est_wdata = '0;
          u_d       = u_q + CNT_W'(1);
        end else begin
          u_d     = '0;
          state_d = S_DEG_HEAD;
        end
      end

      S_DEG_HEAD: begin
        if (u_q < cnt_q) begin
          first_re    = 1'b1;
          first_raddr = u_q[TIDX_W-1:0];
          state_d     = S_DEG_FIRST;
        end else begin
          u_d     = '0;
          tail_d  = '0;
          state_d = S_SCAN;
        end
      end

      S_DEG_FIRST: begin
        e_d     = first_rdata;
        state_d = S_DEG_CHK;
      end

      S_DEG_CHK: begin
        if (e_q == EMPTY) begin
          u_d     = u_q + CNT_W'(1);
          state_d = S_DEG_HEAD;
        end else begin
          tgt_re     = 1'b1;
          tgt_raddr  = e_q[EIDX_W-1:0];
          link_re    = 1'b1;
          link_raddr = e_q[EIDX_W-1:0];
          state_d    = S_DEG_TGT;
        end
      end

      S_DEG_TGT: begin
        v_d = tgt_rdata;
        e_d = link_rdata;
        if (CNT_W'(tgt_rdata) < cnt_q) begin
          deg_re    = 1'b1;
          deg_raddr = tgt_rdata;
          state_d   = S_DEG_INC;
        end else begin
          state_d = S_DEG_CHK;
        end
      end

      S_DEG_INC: begin
        alu_op    = ALU_INC;
        alu_a     = ALU_W'(deg_rdata);
        deg_we    = 1'b1;
        deg_waddr = v_q;
        deg_wdata = DEG_W'(alu_res);
        state_d   = S_DEG_CHK;
      end

      S_SCAN: begin
        if (u_q < cnt_q) begin
          deg_re    = 1'b1;
          deg_raddr = u_q[TIDX_W-1:0];
          state_d   = S_SCAN_CHK;
        end else begin
          head_d  = '0;
          span_d  = '0;
          state_d = S_POP;
        end
      end

      S_SCAN_CHK: begin
        if (deg_rdata == '0) begin
          queue_we    = 1'b1;
          queue_waddr = tail_q[TIDX_W-1:0];
          queue_wdata = u_q[TIDX_W-1:0];
          tail_d      = tail_q + CNT_W'(1);
        end
        u_d     = u_q + CNT_W'(1);
        state_d = S_SCAN;
      end

      S_POP: begin
        if (head_q < tail_q) begin
          queue_re    = 1'b1;
          queue_raddr = head_q[TIDX_W-1:0];
          state_d     = S_POP_U;
        end else begin
          state_d = S_DONE;
        end
      end

      S_POP_U: begin
        pu_d      = queue_rdata;
        head_d    = head_q + CNT_W'(1);
        est_re    = 1'b1;
        est_raddr = queue_rdata;
        dur_re    = 1'b1;
        dur_raddr = queue_rdata;
        state_d   = S_POP_F;
      end

      // Finish time of the popped task.
      S_POP_F: begin
        alu_op      = ALU_ADD;
        alu_a       = ALU_W'(est_rdata);
        alu_b       = ALU_W'(dur_rdata);
        fin_d       = SPAN_W'(alu_res);
        first_re    = 1'b1;
        first_raddr = pu_q;
        state_d     = S_POP_S;
      end

      S_POP_S: begin
        alu_op  = ALU_MAX;
        alu_a   = ALU_W'(span_q);
        alu_b   = ALU_W'(fin_q);
        span_d  = SPAN_W'(alu_res);
        e_d     = first_rdata;
        state_d = S_REL_CHK;
      end

      S_REL_CHK: begin
        if (e_q == EMPTY) begin
          state_d = S_POP;
        end else begin
          tgt_re     = 1'b1;
          tgt_raddr  = e_q[EIDX_W-1:0];
          link_re    = 1'b1;
          link_raddr = e_q[EIDX_W-1:0];
          state_d    = S_REL_TGT;
        end
      end

      S_REL_TGT: begin
        v_d = tgt_rdata;
        e_d = link_rdata;
        if (CNT_W'(tgt_rdata) < cnt_q) begin
          est_re    = 1'b1;
          est_raddr = tgt_rdata;
          deg_re    = 1'b1;
          deg_raddr = tgt_rdata;
          state_d   = S_REL_EST;
        end else begin
          state_d = S_REL_CHK;
        end
      end

      // Raise the successor's earliest start to this finish time.
      S_REL_EST: begin
        alu_op    = ALU_MAX;
        alu_a     = ALU_W'(est_rdata);
        alu_b     = ALU_W'(fin_q);
        est_we    = 1'b1;
        est_waddr = v_q;
        est_wdata = SPAN_W'(alu_res);
        state_d   = S_REL_DEG;
      end

      // Drop one predecessor; a successor with none left joins the queue.
      S_REL_DEG: begin
        alu_op    = ALU_DEC;
        alu_a     = ALU_W'(deg_rdata);
        deg_we    = 1'b1;
        deg_waddr = v_q;
        deg_wdata = DEG_W'(alu_res);
        if (alu_zero && 32'(tail_q) < MAX_TASKS) begin
          queue_we    = 1'b1;
          queue_waddr = tail_q[TIDX_W-1:0];
          queue_wdata = v_q;
          tail_d      = tail_q + CNT_W'(1);
        end
        state_d = S_REL_CHK;
      end

      // Hand over the result word once the output register is free.
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (span_wide > OUT_W'(MAKESPAN_MAX)) begin
            out_word_d.makespan = MAKESPAN_MAX;
          end else begin
            out_word_d.makespan = MAKESPAN_W'(span_wide);
          end
          out_word_d.ordered_count = TASK_COUNT_W'(tail_q);
          out_word_d.cycle_found   = (tail_q < cnt_q);
          out_word_d.edge_overflow = ovf_q;
          u_d     = '0;
          state_d = S_CLEAR;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sim/critical_path_makespan_core_test.sv =====
// Testbench for critical_path_makespan_core.
//
// The block takes words that load task durations and precedence edges, and a
// run word that orders the tasks by Kahn's method and returns one result word:
// makespan, number of tasks ordered, a cycle flag and an edge overflow flag.
// An initial block builds the stimulus phase by phase. Each word is predicted
// here as it is queued, because words are accepted strictly in order. A
// clocked driver feeds the queue to the block. A clocked monitor checks every
// result word against the oldest prediction.
module critical_path_makespan_core_test;
  import cpm_pkg::*;

  localparam int unsigned NUM_TASKS = MAX_TASKS_DEF;
  localparam int unsigned NUM_EDGES = MAX_EDGES_DEF;
  // Quiet time before a task count write. Results have all arrived by then,
  // but a trailing load word or the clearing pass may still be in work.
  localparam int unsigned SETTLE_CYCLES = NUM_TASKS + 200;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [TASK_COUNT_W-1:0] cfg_data_i;

  critical_path_makespan_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the block's state, updated as words are queued.
  // ---------------------------------------------------------------------------
  logic [15:0] dur_mem [NUM_TASKS];
  bit          dur_known [NUM_TASKS];
  int          in_deg [NUM_TASKS];
  int          adj_head [NUM_TASKS];
  int          adj_target [NUM_EDGES];
  int          adj_next [NUM_EDGES];
  longint      start_at [NUM_TASKS];
  int          edges_held;
  bit          edges_lost;
  int unsigned tasks_cfg;

  in_word_t  pending_words[$];
  out_word_t expected_results[$];

  int  errors;
  bit  quiet;      // no idling on either side in the last part of the run
  bit  hold_req;   // asks the receiver for one long hold-off
  bit  in_taken;
  bit  cfg_taken;

  function automatic void clear_graph();
    for (int i = 0; i < NUM_TASKS; i++) begin
      adj_head[i] = -1;
      in_deg[i] = 0;
    end
    edges_held = 0;
    edges_lost = 1'b0;
  endfunction

  // Kahn ordering with a FIFO of ready tasks; successors are visited newest
  // edge first, which is the order the block's linked edge lists give.
  function automatic out_word_t schedule_makespan();
    out_word_t res;
    int        fifo [NUM_TASKS];
    int        count, rd, wr, u, e, v;
    longint    span, finish;
    count = (tasks_cfg > NUM_TASKS) ? NUM_TASKS : tasks_cfg;
    rd = 0;
    wr = 0;
    span = 0;
    for (int i = 0; i < count; i++) begin
      in_deg[i] = 0;
      start_at[i] = 0;
    end
    for (int i = 0; i < count; i++)
      for (e = adj_head[i]; e >= 0; e = adj_next[e])
        if (adj_target[e] < count) in_deg[adj_target[e]]++;
    for (int i = 0; i < count; i++)
      if (in_deg[i] == 0) fifo[wr++] = i;
    while (rd < wr) begin
      u = fifo[rd++];
      finish = start_at[u] + longint'(dur_mem[u]);
      if (finish > span) span = finish;
      for (e = adj_head[u]; e >= 0; e = adj_next[e]) begin
        v = adj_target[e];
        if (v < count) begin
          if (finish > start_at[v]) start_at[v] = finish;
          in_deg[v]--;
          if (in_deg[v] == 0 && wr < NUM_TASKS) fifo[wr++] = v;
        end
      end
    end
    res.makespan      = (span > longint'(MAKESPAN_MAX)) ? MAKESPAN_MAX : span[MAKESPAN_W-1:0];
    res.ordered_count = wr[TASK_COUNT_W-1:0];
    res.cycle_found   = (wr < count);
    res.edge_overflow = edges_lost;
    clear_graph();
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders: each send task queues its word; most also update the shadow state.
  // ---------------------------------------------------------------------------
  function automatic in_word_t noise_word(cmd_e cmd);
    in_word_t w;
    w = in_word_t'(48'({$urandom, $urandom}));
    w.command = cmd;
    return w;
  endfunction

  task automatic queue_word(in_word_t w);
    pending_words = {pending_words, w};
  endtask

  task automatic send_duration(int idx, logic [15:0] value);
    in_word_t w;
    w = noise_word(CMD_SET_DURATION);
    w.task_index = 10'(idx);
    w.duration_value = value;
    dur_mem[idx] = value;
    dur_known[idx] = 1'b1;
    queue_word(w);
  endtask

  task automatic send_edge(int src, int dst);
    in_word_t w;
    w = noise_word(CMD_ADD_EDGE);
    w.edge_from = 10'(src);
    w.edge_to = 10'(dst);
    if (edges_held >= NUM_EDGES) begin
      edges_lost = 1'b1;
    end else begin
      adj_target[edges_held] = dst;
      adj_next[edges_held] = adj_head[src];
      adj_head[src] = edges_held;
      edges_held++;
    end
    queue_word(w);
  endtask

  task automatic send_nop();
    queue_word(noise_word(CMD_NOP));
  endtask

  // A run must never read a duration that was never written, so any task in
  // the problem that still lacks one gets it first.
  task automatic send_run();
    int        count;
    out_word_t want;
    count = (tasks_cfg > NUM_TASKS) ? NUM_TASKS : tasks_cfg;
    for (int i = 0; i < count; i++)
      if (!dur_known[i]) send_duration(i, 16'($urandom));
    queue_word(noise_word(CMD_RUN));
    want = schedule_makespan();
    expected_results = {expected_results, want};
  endtask

  // Waits until every queued word has gone in and every result has come out,
  // then lets the block finish any trailing work.
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_task_count(int unsigned value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= TASK_COUNT_W'(value);
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
    tasks_cfg = value;
  endtask

  // One random problem: mostly an acyclic graph with random durations, with
  // some back edges, out-of-problem endpoints, no-operation words and runs mixed in.
  task automatic random_phase(int words);
    int count, a, b, roll, hi;
    count = (tasks_cfg > NUM_TASKS) ? NUM_TASKS : tasks_cfg;
    // Endpoints just past the problem, but never past the task store.
    hi = (count + 1 < NUM_TASKS) ? count + 1 : NUM_TASKS - 1;
    for (int n = 0; n < words; n++) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        if ($urandom_range(9) == 0) a = $urandom_range(NUM_TASKS - 1);
        else a = $urandom_range(count > 0 ? count - 1 : 0);
        send_duration(a, 16'($urandom));
      end else if (roll < 88) begin
        if ($urandom_range(9) == 0) begin
          a = $urandom_range(NUM_TASKS - 1);
          b = $urandom_range(NUM_TASKS - 1);
        end else begin
          a = $urandom_range(hi);
          b = $urandom_range(hi);
          // Keep most edges pointing forwards so the problem stays mostly acyclic.
          if (a > b && $urandom_range(9) != 0) begin
            roll = a;
            a = b;
            b = roll;
          end
        end
        send_edge(a, b);
      end else if (roll < 91) begin
        send_nop();
      end else begin
        send_run();
      end
    end
    send_run();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: a new word or an idle burst is chosen at the falling edge after
  // the previous word was taken.
  // ---------------------------------------------------------------------------
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      cfg_taken <= cfg_valid_i && cfg_ready_o;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(5) == 0) begin
        gap_left <= $urandom_range(2);
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_word_i <= pending_words.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: short random stalls, plus one long hold-off on request so that
  // a run result backs up and the input side has to stall.
  // ---------------------------------------------------------------------------
  int stall_left;
  int hold_left;

  always @(negedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_req <= 1'b0;
      hold_left <= 4000;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= (hold_left == 1);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(4) == 0) begin
      stall_left <= $urandom_range(2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted result word is checked field by field.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: %s is %0d, predicted %0d", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result word, makespan", out_word_o.makespan, -1);
      end else begin
        want = expected_results.pop_front();
        if (out_word_o.makespan !== want.makespan)
          report_mismatch("makespan", out_word_o.makespan, want.makespan);
        if (out_word_o.ordered_count !== want.ordered_count)
          report_mismatch("ordered_count", out_word_o.ordered_count, want.ordered_count);
        if (out_word_o.cycle_found !== want.cycle_found)
          report_mismatch("cycle_found", out_word_o.cycle_found, want.cycle_found);
        if (out_word_o.edge_overflow !== want.edge_overflow)
          report_mismatch("edge_overflow", out_word_o.edge_overflow, want.edge_overflow);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    errors = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    gap_left = 0;
    stall_left = 0;
    hold_left = 0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    tasks_cfg = TASK_COUNT_RST;
    for (int i = 0; i < NUM_TASKS; i++) begin
      dur_mem[i] = '0;
      dur_known[i] = 1'b0;
      start_at[i] = 0;
    end
    clear_graph();
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, with the reset task count of one first: a single task.
    send_duration(0, 16'hFFFF);
    send_nop();
    send_run();
    wait_idle();

    // Five tasks: a diamond, a self loop on a task beyond the problem, an edge
    // out of the problem, and the extreme durations and endpoints.
    write_task_count(5);
    send_duration(0, 16'd0);
    send_duration(1, 16'hFFFF);
    send_duration(2, 16'h5A5A);
    send_duration(3, 16'hA5A5);
    send_duration(4, 16'd1);
    send_duration(NUM_TASKS - 1, 16'hFFFF);
    send_edge(0, 1);
    send_edge(0, 2);
    send_edge(1, 3);
    send_edge(2, 3);
    send_edge(3, 4);
    send_edge(4, NUM_TASKS - 1);
    send_edge(NUM_TASKS - 1, NUM_TASKS - 1);
    send_run();
    // The same tasks with a cycle between two of them: both are skipped.
    send_edge(0, 1);
    send_edge(1, 2);
    send_edge(2, 1);
    send_nop();
    send_run();
    wait_idle();

    // An empty problem still returns a result word; its overflow flag stays clear.
    write_task_count(0);
    send_edge(0, 1);
    send_run();
    wait_idle();

    // The full task count with a chain through every task, and then a count above
    // it that is taken as the maximum.
    write_task_count(NUM_TASKS);
    for (int i = 0; i + 1 < NUM_TASKS; i++) send_edge(i, i + 1);
    send_run();
    wait_idle();
    write_task_count((1 << TASK_COUNT_W) - 1);
    send_edge(NUM_TASKS - 1, 0);
    send_edge(5, 9);
    send_run();
    wait_idle();

    // Edge store overflow: a few edges more than it holds, then a clean run.
    write_task_count(8);
    for (int i = 0; i < NUM_EDGES + 4; i++) begin
      int a;
      a = $urandom_range(6);
      send_edge(a, $urandom_range(7, a + 1));
    end
    send_run();
    send_run();
    wait_idle();

    // Random problems, most of them small. One long receiver hold-off lands
    // while a busy phase keeps words coming.
    for (int p = 0; p < 10; p++) begin
      if (p == 9) quiet = 1'b1;
      write_task_count($urandom_range(9) == 0 ? $urandom_range(NUM_TASKS, 1)
                                             : $urandom_range(40, 1));
      if (p == 3) hold_req = 1'b1;
      random_phase(50);
      wait_idle();
    end

    if (errors == 0) begin
      $display("critical_path_makespan_core: match");
    end else begin
      $display("critical_path_makespan_core: mismatch");
    end
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("critical_path_makespan_core: mismatch");
    $finish;
  end

endmodule

// ===== critical_path_makespan_core.f =====
hdl/cpm_pkg.sv
hdl/cpm_ram.sv
hdl/cpm_alu.sv
hdl/critical_path_makespan_core.sv
sim/critical_path_makespan_core_test.sv
